// File: hw/rtl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types and constants for the Modbus RTU master
// Request and result structs, queue entry type, command classes, function
// codes, status codes and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mrtu_pkg;

  // Input request fields.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] reg_address;
    logic [6:0]  word_count;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [7:0]  rx_data;
  } in_item_t;

  // Result fields.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_data;
    logic        tx_last;
    logic [2:0]  status;
    logic [15:0] word_out;
  } out_item_t;

  // Command codes on the input.
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_LOAD  = 3'd1;
  localparam logic [2:0] CMD_TXRDY = 3'd2;
  localparam logic [2:0] CMD_RXB   = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // Classes assigned by the front end.
  localparam logic [2:0] CL_NOP   = 3'd0;
  localparam logic [2:0] CL_START = 3'd1;
  localparam logic [2:0] CL_LOAD  = 3'd2;
  localparam logic [2:0] CL_TXRDY = 3'd3;
  localparam logic [2:0] CL_RXB   = 3'd4;
  localparam logic [2:0] CL_TICK  = 3'd5;
  localparam logic [2:0] CL_READ  = 3'd6;

  // Queue entry between front and back.
  typedef struct packed {
    logic [2:0] cls;
    in_item_t   item;
  } q_entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Result kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TX   = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_WORD = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_SLAVE   = 3'd4;
  localparam logic [2:0] ST_COUNT   = 3'd5;

  // Supported function codes.
  localparam logic [7:0] FN_RD_HOLD  = 8'h03;
  localparam logic [7:0] FN_RD_INPUT = 8'h04;
  localparam logic [7:0] FN_WR_COIL  = 8'h05;
  localparam logic [7:0] FN_WR_REG   = 8'h06;
  localparam logic [7:0] FN_EXC_STAT = 8'h07;
  localparam logic [7:0] FN_DIAG     = 8'h08;
  localparam logic [7:0] FN_WR_MULTI = 8'h10;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_ATTEMPTS = 2'd1;

  // One byte of reflected CRC-16 (polynomial 0xA001).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/mrtu_ram.sv
// ----------------------------------------------------------------------------
// mrtu_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/mrtu_front.sv
// ----------------------------------------------------------------------------
// mrtu_front: request intake and classification
// Accepts requests, tags each with its command class and holds them in a
// short queue until the engine takes them.
// ----------------------------------------------------------------------------
module mrtu_front import mrtu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     q_valid,
  input  logic     q_pop,
  output q_entry_t q_head
);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic [2:0]        cls;

  // Classify the incoming command.
  always_comb begin
    unique case (in_item.cmd)
      CMD_START: cls = CL_START;
      CMD_LOAD:  cls = CL_LOAD;
      CMD_TXRDY: cls = CL_TXRDY;
      CMD_RXB:   cls = CL_RXB;
      CMD_TICK:  cls = CL_TICK;
      CMD_READ:  cls = CL_READ;
      default:   cls = CL_NOP;
    endcase
  end

  assign in_stall = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = entries[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= '{cls: cls, item: in_item};
  end

endmodule

// File: hw/rtl/mrtu_back.sv
// ----------------------------------------------------------------------------
// mrtu_back: transaction engine
// Builds the request frame, hands out request bytes, collects and checks
// the response, runs the retry timer and drives the result register.
// ----------------------------------------------------------------------------
module mrtu_back import mrtu_pkg::*; #(
  parameter int FRAME_BYTES = 256,
  parameter int WORD_STORE  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  q_entry_t    q_head,
  input  logic [15:0] timeout_ticks,
  input  logic [3:0]  max_attempts,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int WA_W = $clog2(WORD_STORE);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SEND  = 2'd1;
  localparam logic [1:0] PH_RECV  = 2'd2;
  localparam logic [1:0] PH_BUILD = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [7:0]  tx_position, tx_position_next;
  logic [7:0]  tx_length, tx_length_next;
  logic [7:0]  rx_position, rx_position_next;
  logic [7:0]  rx_expected, rx_expected_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] tick_count, tick_count_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic [1:0]  header_flags, header_flags_next;
  logic [7:0]  sv_slave, sv_slave_next;
  logic [7:0]  sv_fn, sv_fn_next;
  logic [6:0]  sv_cnt, sv_cnt_next;
  logic [7:0]  rx_hi, rx_hi_next;
  logic [7:0]  bld_pos, bld_pos_next;
  logic [7:0]  bld_len, bld_len_next;
  logic [15:0] bld_crc, bld_crc_next;
  logic [15:0] bld_addr, bld_addr_next;
  logic [15:0] bld_data, bld_data_next;

  logic       b_valid, b_valid_next;
  logic [1:0] b_kind, b_kind_next;
  logic [2:0] b_status, b_status_next;
  logic       b_last, b_last_next;
  logic       b_tx_sel, b_tx_sel_next;
  logic       b_res_sel, b_res_sel_next;

  logic            fr_we, fr_re;
  logic [FA_W-1:0] fr_waddr;
  logic [7:0]      fr_wdata, fr_rdata;
  logic            ww_we, ww_re;
  logic [WA_W-1:0] ww_waddr, ww_raddr;
  logic [15:0]     ww_rdata;
  logic            rs_we, rs_re;
  logic [WA_W-1:0] rs_waddr;
  logic [15:0]     rs_wdata, rs_rdata;

  in_item_t    it;
  logic        fire;
  logic [2:0]  start_st;
  logic        cnt_ok_rd, cnt_ok_wr;
  logic [7:0]  hdr_byte, bld_byte, off;
  logic [7:0]  ww_off;
  logic [6:0]  wsel;
  logic [15:0] crc_n, tc;
  logic [7:0]  rxp_n;
  logic [3:0]  ac;
  logic [1:0]  fl;

  assign it   = q_head.item;
  assign fire = q_valid && (!b_valid || !out_stall) && (phase != PH_BUILD);
  assign q_pop = fire;

  // Request validation on start.
  assign cnt_ok_rd = (it.word_count != 7'd0) && (it.word_count <= 7'd125) &&
                     ({1'b0, it.word_count} <= 8'(WORD_STORE));
  assign cnt_ok_wr = (it.word_count != 7'd0) && (it.word_count <= 7'd123) &&
                     ({1'b0, it.word_count} <= 8'(WORD_STORE)) &&
                     ((10'd9 + {2'b00, it.word_count, 1'b0}) <= 10'(FRAME_BYTES));

  always_comb begin
    case (it.function_code)
      FN_RD_HOLD, FN_RD_INPUT: start_st = cnt_ok_rd ? ST_OK : ST_COUNT;
      FN_WR_MULTI:             start_st = cnt_ok_wr ? ST_OK : ST_COUNT;
      FN_WR_COIL, FN_WR_REG, FN_EXC_STAT, FN_DIAG: start_st = ST_OK;
      default:                 start_st = ST_UNKNOWN;
    endcase
  end

  // Header byte of the frame under construction.
  always_comb begin
    case (bld_pos[2:0])
      3'd0:    hdr_byte = sv_slave;
      3'd1:    hdr_byte = sv_fn;
      3'd2:    hdr_byte = bld_addr[15:8];
      3'd3:    hdr_byte = bld_addr[7:0];
      3'd4:    hdr_byte = bld_data[15:8];
      3'd5:    hdr_byte = bld_data[7:0];
      default: hdr_byte = {sv_cnt, 1'b0};
    endcase
  end

  assign bld_byte = (bld_pos < 8'd7) ? hdr_byte :
                    (bld_pos[0] ? ww_rdata[15:8] : ww_rdata[7:0]);

  // Byte offset from the byte-count field of the frame, used to address the write words.
  assign ww_off = bld_pos - 8'd6;

  // Next-state logic for the engine.
  always_comb begin
    phase_next         = phase;
    tx_position_next   = tx_position;
    tx_length_next     = tx_length;
    rx_position_next   = rx_position;
    rx_expected_next   = rx_expected;
    running_crc_next   = running_crc;
    tick_count_next    = tick_count;
    attempt_count_next = attempt_count;
    header_flags_next  = header_flags;
    sv_slave_next      = sv_slave;
    sv_fn_next         = sv_fn;
    sv_cnt_next        = sv_cnt;
    rx_hi_next         = rx_hi;
    bld_pos_next       = bld_pos;
    bld_len_next       = bld_len;
    bld_crc_next       = bld_crc;
    bld_addr_next      = bld_addr;
    bld_data_next      = bld_data;
    b_valid_next       = b_valid;
    b_kind_next        = b_kind;
    b_status_next      = b_status;
    b_last_next        = b_last;
    b_tx_sel_next      = b_tx_sel;
    b_res_sel_next     = b_res_sel;
    fr_we = 1'b0; fr_re = 1'b0; fr_waddr = bld_pos[FA_W-1:0]; fr_wdata = bld_byte;
    ww_we = 1'b0; ww_re = 1'b0;
    ww_waddr = it.word_index[WA_W-1:0];
    ww_raddr = ww_off[WA_W:1];
    rs_we = 1'b0; rs_re = 1'b0; rs_waddr = '0; rs_wdata = '0;
    off   = rx_position - 8'd3;
    wsel  = off[7:1];
    crc_n = crc_byte(running_crc, it.rx_data);
    rxp_n = rx_position + 8'd1;
    tc    = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
    ac    = (attempt_count != 4'd15) ? attempt_count + 4'd1 : attempt_count;
    fl    = header_flags;

    // Frame build: header, snapshot of write words, then the CRC.
    if (phase == PH_BUILD) begin
      fr_we = 1'b1;
      if (bld_pos >= 8'd6 && !bld_pos[0]) ww_re = 1'b1;
      if (bld_pos < bld_len) begin
        bld_crc_next = crc_byte(bld_crc, bld_byte);
      end else if (bld_pos == bld_len) begin
        fr_wdata = bld_crc[7:0];
      end else begin
        fr_wdata   = bld_crc[15:8];
        phase_next = PH_SEND;
      end
      bld_pos_next = bld_pos + 8'd1;
    end

    // Request handling: result register load, or release when not stalled.
    if (fire) begin
      b_valid_next   = 1'b1;
      b_kind_next    = KIND_NONE;
      b_status_next  = ST_OK;
      b_last_next    = 1'b0;
      b_tx_sel_next  = 1'b0;
      b_res_sel_next = 1'b0;
      unique case (q_head.cls)
        CL_START: begin
          if (phase == PH_IDLE) begin
            if (start_st != ST_OK) begin
              b_kind_next   = KIND_DONE;
              b_status_next = start_st;
            end else begin
              sv_slave_next = it.slave_id;
              sv_fn_next    = it.function_code;
              sv_cnt_next   = it.word_count;
              bld_addr_next = (it.function_code == FN_DIAG) ? 16'h0000 : it.reg_address;
              if (it.function_code == FN_WR_COIL || it.function_code == FN_WR_REG)
                bld_data_next = it.word_value;
              else if (it.function_code == FN_DIAG)
                bld_data_next = 16'h0000;
              else
                bld_data_next = {9'd0, it.word_count};
              if (it.function_code == FN_EXC_STAT) bld_len_next = 8'd2;
              else if (it.function_code == FN_WR_MULTI)
                bld_len_next = 8'd7 + {it.word_count, 1'b0};
              else bld_len_next = 8'd6;
              tx_length_next = bld_len_next + 8'd2;
              if (it.function_code == FN_RD_HOLD || it.function_code == FN_RD_INPUT)
                rx_expected_next = 8'd5 + {it.word_count, 1'b0};
              else if (it.function_code == FN_EXC_STAT) rx_expected_next = 8'd5;
              else rx_expected_next = 8'd8;
              bld_pos_next       = 8'd0;
              bld_crc_next       = 16'hFFFF;
              attempt_count_next = 4'd0;
              phase_next         = PH_BUILD;
              tx_position_next   = 8'd0;
              rx_position_next   = 8'd0;
              running_crc_next   = 16'hFFFF;
              tick_count_next    = 16'd0;
              header_flags_next  = 2'b00;
            end
          end
        end
        CL_LOAD: begin
          if ({1'b0, it.word_index} < 8'(WORD_STORE)) ww_we = 1'b1;
        end
        CL_TXRDY: begin
          if (phase == PH_SEND && tx_position < tx_length) begin
            b_kind_next      = KIND_TX;
            b_tx_sel_next    = 1'b1;
            b_last_next      = (tx_position + 8'd1 == tx_length);
            fr_re            = 1'b1;
            tx_position_next = tx_position + 8'd1;
            if (tx_position + 8'd1 == tx_length) phase_next = PH_RECV;
          end
        end
        CL_RXB: begin
          if (phase == PH_RECV) begin
            if (rx_position == 8'd0 && it.rx_data != sv_slave) fl[0] = 1'b1;
            if (rx_position == 8'd1 && it.rx_data != sv_fn) fl[1] = 1'b1;
            header_flags_next = fl;
            // Read data words land as they arrive, high byte first.
            if ((sv_fn == FN_RD_HOLD || sv_fn == FN_RD_INPUT) && rx_position >= 8'd3 &&
                {1'b0, rx_position} < (9'd3 + {1'b0, sv_cnt, 1'b0}) &&
                {1'b0, wsel} < 8'(WORD_STORE)) begin
              rs_we    = 1'b1;
              rs_waddr = wsel[WA_W-1:0];
              if (off[0]) begin
                rs_wdata = {rx_hi, it.rx_data};
              end else begin
                rs_wdata   = {it.rx_data, 8'h00};
                rx_hi_next = it.rx_data;
              end
            end
            if (sv_fn == FN_EXC_STAT && rx_position == 8'd2) begin
              rs_we    = 1'b1;
              rs_waddr = '0;
              rs_wdata = {8'h00, it.rx_data};
            end
            running_crc_next = crc_n;
            rx_position_next = rxp_n;
            if (rxp_n >= rx_expected) begin
              phase_next  = PH_IDLE;
              b_kind_next = KIND_DONE;
              if (fl[0]) b_status_next = ST_SLAVE;
              else if (fl[1] || crc_n != 16'h0000) b_status_next = ST_BAD;
              else b_status_next = ST_OK;
            end
          end
        end
        CL_TICK: begin
          if (phase == PH_RECV) begin
            tick_count_next = tc;
            if (tc >= timeout_ticks) begin
              attempt_count_next = ac;
              if (ac >= max_attempts) begin
                phase_next    = PH_IDLE;
                b_kind_next   = KIND_DONE;
                b_status_next = ST_TIMEOUT;
              end else begin
                phase_next        = PH_SEND;
                tx_position_next  = 8'd0;
                rx_position_next  = 8'd0;
                running_crc_next  = 16'hFFFF;
                tick_count_next   = 16'd0;
                header_flags_next = 2'b00;
              end
            end
          end
        end
        CL_READ: begin
          b_kind_next = KIND_WORD;
          if ({1'b0, it.word_index} < 8'(WORD_STORE)) begin
            rs_re          = 1'b1;
            b_res_sel_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (!out_stall) begin
      b_valid_next = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tx_position   <= 8'd0;
      tx_length     <= 8'd0;
      rx_position   <= 8'd0;
      rx_expected   <= 8'd0;
      running_crc   <= 16'hFFFF;
      tick_count    <= 16'd0;
      attempt_count <= 4'd0;
      header_flags  <= 2'b00;
      sv_slave      <= 8'd0;
      sv_fn         <= 8'd0;
      sv_cnt        <= 7'd0;
      bld_pos       <= 8'd0;
      bld_len       <= 8'd0;
      b_valid       <= 1'b0;
    end else begin
      phase         <= phase_next;
      tx_position   <= tx_position_next;
      tx_length     <= tx_length_next;
      rx_position   <= rx_position_next;
      rx_expected   <= rx_expected_next;
      running_crc   <= running_crc_next;
      tick_count    <= tick_count_next;
      attempt_count <= attempt_count_next;
      header_flags  <= header_flags_next;
      sv_slave      <= sv_slave_next;
      sv_fn         <= sv_fn_next;
      sv_cnt        <= sv_cnt_next;
      bld_pos       <= bld_pos_next;
      bld_len       <= bld_len_next;
      b_valid       <= b_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rx_hi     <= rx_hi_next;
    bld_crc   <= bld_crc_next;
    bld_addr  <= bld_addr_next;
    bld_data  <= bld_data_next;
    b_kind    <= b_kind_next;
    b_status  <= b_status_next;
    b_last    <= b_last_next;
    b_tx_sel  <= b_tx_sel_next;
    b_res_sel <= b_res_sel_next;
  end

  // Request frame, write words and result words.
  mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .re(fr_re), .raddr(tx_position[FA_W-1:0]), .rdata(fr_rdata)
  );

  mrtu_ram #(.WIDTH(16), .DEPTH(WORD_STORE)) u_wwords (
    .clk(clk), .we(ww_we), .waddr(ww_waddr), .wdata(it.word_value),
    .re(ww_re), .raddr(ww_raddr), .rdata(ww_rdata)
  );

  mrtu_ram #(.WIDTH(16), .DEPTH(WORD_STORE)) u_rwords (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .re(rs_re), .raddr(it.word_index[WA_W-1:0]), .rdata(rs_rdata)
  );

  // Result output.
  assign out_valid        = b_valid;
  assign out_item.kind    = b_kind;
  assign out_item.tx_data = b_tx_sel ? fr_rdata : 8'h00;
  assign out_item.tx_last = b_last;
  assign out_item.status  = b_status;
  assign out_item.word_out = b_res_sel ? rs_rdata : 16'h0000;

endmodule

// File: hw/rtl/modbus_rtu_master_transaction.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_transaction: Modbus RTU master, one transaction at a time
// Front end queues requests, engine builds frames, retries and checks
// responses; configuration registers set timeout and attempt limit.
//
// Channel   Handshake          Payload
// in        in_valid/in_stall  in_item    (in_item_t)
// out       out_valid/out_stall out_item  (out_item_t)
// cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Every request yields exactly one result; one request per cycle sustained
// outside frame builds while out_stall does not hold the result register. A
// valid start holds the engine while its frame (at most FRAME_BYTES bytes,
// CRC included) is built; the 4-entry queue keeps accepting until it is full.
// Synchronous active-high reset; the result register holds under out_stall
// and the queue stalls the input when full.
// ----------------------------------------------------------------------------
module modbus_rtu_master_transaction import mrtu_pkg::*; #(
  parameter int FRAME_BYTES = 256,
  parameter int WORD_STORE  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        q_valid;
  logic        q_pop;
  q_entry_t    q_head;
  logic [15:0] response_timeout_ticks;
  logic [3:0]  max_attempts;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_timeout_ticks <= 16'd1000;
      max_attempts           <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT:  response_timeout_ticks <= cfg_data;
        CFG_ATTEMPTS: max_attempts           <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  mrtu_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
  );

  mrtu_back #(.FRAME_BYTES(FRAME_BYTES), .WORD_STORE(WORD_STORE)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
    .timeout_ticks(response_timeout_ticks), .max_attempts(max_attempts),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

`ifndef SYNTHESIS
  // The engine only pops a queue entry that is present.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A popped request always lands in the result register.
  a_pop_out: assert property (@(posedge clk) disable iff (rst) q_pop |=> out_valid)
    else $error("popped request produced no result");

  // Only transmit results carry a last-byte mark.
  a_last_tx: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.tx_last) |-> (out_item.kind == KIND_TX))
    else $error("tx_last on a non-transmit result");

  // Status is only nonzero on a finished transaction.
  a_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status != ST_OK) |-> (out_item.kind == KIND_DONE))
    else $error("status on a result that is not a finish");
`endif

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the Modbus RTU master transaction block
// A shadow model of the master predicts one result for every accepted
// request. A checker compares each result field by field, in order. Directed
// tests cover every function, the status cases and the configuration
// extremes. Random transactions then run with random idling on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import mrtu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;

  // Transaction flavors for the response generator.
  typedef enum int {
    RSP_GOOD, RSP_SILENT, RSP_BAD_SLAVE, RSP_BAD_FN, RSP_BAD_CRC, RSP_LATE
  } rsp_mode_e;
  typedef enum int {M_IDLE, M_SEND, M_RECV} master_phase_e;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  modbus_rtu_master_transaction i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow state of the master.
  logic [7:0]    frame_sh [256];
  logic [15:0]   wr_words_sh [128];
  logic [15:0]   rd_words_sh [128];
  bit            wr_loaded [128];
  bit            rd_loaded [128];
  master_phase_e phase_sh;
  int            tx_pos, tx_len, rx_pos, rx_len;
  logic [15:0]   rx_crc, ticks_sh;
  int            attempts_sh;
  logic [1:0]    hdr_err;
  logic [7:0]    req_slave, req_fn, req_cnt;
  logic [15:0]   timeout_sh;
  logic [3:0]    max_att_sh;

  // Response plan for the transaction in flight.
  logic [7:0]    rsp_bytes [$];
  rsp_mode_e     txn_mode;

  out_item_t     expected_results [$];
  int            error_count;
  int            items_sent;
  int            txn_count;
  int            status_seen [8];
  bit            no_idle;
  bit            hold_req;

  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Start of one attempt: counters cleared, frame kept.
  function automatic void restart_attempt();
    phase_sh = M_SEND;
    tx_pos   = 0;
    rx_pos   = 0;
    rx_crc   = 16'hFFFF;
    ticks_sh = '0;
    hdr_err  = '0;
  endfunction

  // Checks a start request and builds its frame; returns the status.
  function automatic logic [2:0] build_request(in_item_t it);
    int len;
    logic [15:0] d, crc;
    logic [7:0] hi, lo;
    case (it.function_code)
      FN_RD_HOLD, FN_RD_INPUT:
        if (it.word_count < 1 || it.word_count > 125) return ST_COUNT;
      FN_WR_MULTI:
        if (it.word_count < 1 || it.word_count > 123) return ST_COUNT;
      FN_WR_COIL, FN_WR_REG, FN_EXC_STAT, FN_DIAG: ;
      default: return ST_UNKNOWN;
    endcase
    frame_sh[0] = it.slave_id;
    frame_sh[1] = it.function_code;
    if (it.function_code == FN_EXC_STAT) begin
      len = 2;
    end else begin
      hi = it.reg_address[15:8];
      lo = it.reg_address[7:0];
      d  = {9'd0, it.word_count};
      if (it.function_code inside {FN_WR_COIL, FN_WR_REG}) d = it.word_value;
      if (it.function_code == FN_DIAG) begin
        hi = '0; lo = '0; d = '0;
      end
      frame_sh[2] = hi;
      frame_sh[3] = lo;
      frame_sh[4] = d[15:8];
      frame_sh[5] = d[7:0];
      len = 6;
      if (it.function_code == FN_WR_MULTI) begin
        frame_sh[6] = 8'(it.word_count * 2);
        for (int i = 0; i < it.word_count; i++) begin
          frame_sh[7 + 2 * i] = wr_words_sh[i][15:8];
          frame_sh[8 + 2 * i] = wr_words_sh[i][7:0];
        end
        len = 7 + 2 * it.word_count;
      end
    end
    crc = 16'hFFFF;
    for (int i = 0; i < len; i++) crc = crc16_update(crc, frame_sh[i]);
    frame_sh[len]     = crc[7:0];
    frame_sh[len + 1] = crc[15:8];
    tx_len = len + 2;
    if (it.function_code inside {FN_RD_HOLD, FN_RD_INPUT}) rx_len = 5 + 2 * it.word_count;
    else if (it.function_code == FN_EXC_STAT) rx_len = 5;
    else rx_len = 8;
    req_slave   = it.slave_id;
    req_fn      = it.function_code;
    req_cnt     = {1'b0, it.word_count};
    attempts_sh = 0;
    restart_attempt();
    return ST_OK;
  endfunction

  // Plans the slave's answer, corrupted as the transaction flavor says.
  task automatic plan_response();
    logic [15:0] crc;
    int pos;
    rsp_bytes = {};
    rsp_bytes.push_back(req_slave);
    rsp_bytes.push_back(req_fn);
    for (int i = 2; i < rx_len - 2; i++) rsp_bytes.push_back(8'($urandom()));
    if (req_fn inside {FN_RD_HOLD, FN_RD_INPUT}) rsp_bytes[2] = 8'(req_cnt * 2);
    crc = 16'hFFFF;
    foreach (rsp_bytes[i]) crc = crc16_update(crc, rsp_bytes[i]);
    rsp_bytes.push_back(crc[7:0]);
    rsp_bytes.push_back(crc[15:8]);
    case (txn_mode)
      RSP_BAD_SLAVE: rsp_bytes[0] ^= 8'($urandom_range(1, 255));
      RSP_BAD_FN:    rsp_bytes[1] ^= 8'($urandom_range(1, 255));
      RSP_BAD_CRC: begin
        pos = $urandom_range(2, rx_len - 1);
        rsp_bytes[pos] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
  endtask

  // Advances the shadow model by one accepted request.
  task automatic predict_result(in_item_t it);
    out_item_t e;
    logic [7:0] b;
    int w;
    e = '0;
    case (it.cmd)
      CMD_START:
        if (phase_sh == M_IDLE) begin
          e.status = build_request(it);
          if (e.status != ST_OK) e.kind = KIND_DONE;
          else e.status = ST_OK;
        end
      CMD_LOAD: begin
        wr_words_sh[it.word_index] = it.word_value;
        wr_loaded[it.word_index]   = 1'b1;
      end
      CMD_TXRDY:
        if (phase_sh == M_SEND && tx_pos < tx_len) begin
          e.kind    = KIND_TX;
          e.tx_data = frame_sh[tx_pos];
          e.tx_last = (tx_pos + 1 == tx_len);
          tx_pos++;
          if (e.tx_last) begin
            phase_sh = M_RECV;
            plan_response();
          end
        end
      CMD_RXB:
        if (phase_sh == M_RECV) begin
          b = it.rx_data;
          if (rx_pos == 0 && b != req_slave) hdr_err[0] = 1'b1;
          if (rx_pos == 1 && b != req_fn) hdr_err[1] = 1'b1;
          if (req_fn inside {FN_RD_HOLD, FN_RD_INPUT} && rx_pos >= 3 &&
              rx_pos < 3 + 2 * req_cnt) begin
            w = (rx_pos - 3) >> 1;
            if (((rx_pos - 3) & 1) == 0) begin
              rd_words_sh[w] = {b, 8'h00};
              rd_loaded[w]   = 1'b1;
            end else begin
              rd_words_sh[w] = rd_words_sh[w] | {8'h00, b};
            end
          end
          if (req_fn == FN_EXC_STAT && rx_pos == 2) begin
            rd_words_sh[0] = {8'h00, b};
            rd_loaded[0]   = 1'b1;
          end
          rx_crc = crc16_update(rx_crc, b);
          rx_pos++;
          if (rx_pos >= rx_len) begin
            if (hdr_err[0]) e.status = ST_SLAVE;
            else if (hdr_err[1] || rx_crc != 0) e.status = ST_BAD;
            else e.status = ST_OK;
            e.kind   = KIND_DONE;
            phase_sh = M_IDLE;
          end
        end
      CMD_TICK:
        if (phase_sh == M_RECV) begin
          if (ticks_sh != 16'hFFFF) ticks_sh++;
          if (ticks_sh >= timeout_sh) begin
            if (attempts_sh < 15) attempts_sh++;
            if (attempts_sh >= max_att_sh) begin
              phase_sh = M_IDLE;
              e.kind   = KIND_DONE;
              e.status = ST_TIMEOUT;
            end else begin
              restart_attempt();
            end
          end
        end
      CMD_READ: begin
        e.kind     = KIND_WORD;
        e.word_out = rd_words_sh[it.word_index];
      end
      default: ;
    endcase
    if (e.kind == KIND_DONE) begin
      txn_count++;
      status_seen[e.status]++;
    end
    expected_results.push_back(e);
  endtask

  // Sends one request with random idling and predicts it on acceptance.
  task automatic send_request(in_item_t it);
    while (!no_idle && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    predict_result(it);
  endtask

  // Writes one register; only called once all expected results have drained.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TIMEOUT) timeout_sh = value;
    else max_att_sh = value[3:0];
  endtask

  // Lets every expected result arrive, then the frame build time.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] ticks, logic [15:0] attempts);
    drain_results();
    write_register(CFG_TIMEOUT, ticks);
    write_register(CFG_ATTEMPTS, attempts);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [2:0] noise_cmd();
    case ($urandom_range(4))
      0: return CMD_TXRDY;
      1: return CMD_RXB;
      2: return CMD_TICK;
      3: return CMD_SPARE6;
      default: return CMD_SPARE7;
    endcase
  endfunction

  // A read of a result word that has been written, or a spare command.
  task automatic make_read(inout in_item_t it);
    int idx;
    it.cmd = CMD_SPARE7;
    idx = $urandom_range(127);
    for (int k = 0; k < 128; k++)
      if (rd_loaded[(idx + k) % 128]) begin
        it.cmd        = CMD_READ;
        it.word_index = 7'((idx + k) % 128);
        return;
      end
  endtask

  // A start request, mostly well formed, with a random response flavor.
  task automatic make_start(inout in_item_t it);
    logic [7:0] fns [7];
    int p, prefix;
    fns = '{FN_RD_HOLD, FN_RD_INPUT, FN_WR_COIL, FN_WR_REG, FN_EXC_STAT,
            FN_DIAG, FN_WR_MULTI};
    it.cmd = CMD_START;
    if ($urandom_range(99) < 90) it.function_code = fns[$urandom_range(6)];
    p = $urandom_range(99);
    if (it.function_code inside {FN_RD_HOLD, FN_RD_INPUT}) begin
      if (p < 90) it.word_count = 7'($urandom_range(1, 8));
      else if (p < 94) it.word_count = 7'($urandom_range(9, 125));
      else it.word_count = ($urandom_range(1)) ? 7'd0 : 7'($urandom_range(126, 127));
    end else if (it.function_code == FN_WR_MULTI) begin
      prefix = 0;
      while (prefix < 128 && wr_loaded[prefix]) prefix++;
      if (p < 90 && prefix > 0) it.word_count = 7'($urandom_range(1, (prefix < 8) ? prefix : 8));
      else it.word_count = ($urandom_range(1)) ? 7'd0 : 7'($urandom_range(124, 127));
    end
    p = $urandom_range(99);
    if (p < 60) txn_mode = RSP_GOOD;
    else if (p < 75) txn_mode = RSP_SILENT;
    else if (p < 82) txn_mode = RSP_BAD_SLAVE;
    else if (p < 89) txn_mode = RSP_BAD_FN;
    else if (p < 96) txn_mode = RSP_BAD_CRC;
    else txn_mode = RSP_LATE;
  endtask

  // Next request, chosen from the shadow phase.
  task automatic next_request(output in_item_t it);
    logic [95:0] r;
    int p;
    bit quiet;
    r  = {$urandom(), $urandom(), $urandom()};
    it = r[$bits(in_item_t)-1:0];
    p  = $urandom_range(99);
    case (phase_sh)
      M_IDLE:
        if (p < 45) make_start(it);
        else if (p < 65) it.cmd = CMD_LOAD;
        else if (p < 80) make_read(it);
        else it.cmd = noise_cmd();
      M_SEND:
        if (p < 85) it.cmd = CMD_TXRDY;
        else if (p < 90) it.cmd = CMD_START;
        else if (p < 95) make_read(it);
        else it.cmd = ($urandom_range(1)) ? CMD_TICK : CMD_SPARE6;
      default: begin
        quiet = (txn_mode == RSP_SILENT) || (txn_mode == RSP_LATE && attempts_sh == 0);
        if (quiet) begin
          it.cmd = (p < 90) ? CMD_TICK : CMD_TXRDY;
        end else if (p < 85) begin
          it.cmd     = CMD_RXB;
          it.rx_data = rsp_bytes[rx_pos];
        end else if (p < 90) begin
          it.cmd = CMD_TICK;
        end else if (p < 95) begin
          make_read(it);
        end else begin
          it.cmd = CMD_START;
        end
      end
    endcase
  endtask

  // One whole transaction with a forced function, count and flavor.
  task automatic run_transaction(logic [7:0] fn, logic [6:0] cnt, rsp_mode_e mode);
    in_item_t it;
    next_request(it);
    make_start(it);
    it.function_code = fn;
    it.word_count    = cnt;
    txn_mode         = mode;
    send_request(it);
    while (phase_sh != M_IDLE) begin
      next_request(it);
      send_request(it);
    end
  endtask

  task automatic random_requests(int n);
    in_item_t it;
    repeat (n) begin
      next_request(it);
      send_request(it);
    end
  endtask

  task automatic test_config_extremes();
    configure(16'hFFFF, 16'd8);
    run_transaction(FN_RD_HOLD, 7'd1, RSP_GOOD);
    configure(16'd0, 16'd0);
    run_transaction(FN_DIAG, 7'd0, RSP_SILENT);
    configure(16'd1, 16'd15);
    run_transaction(FN_WR_REG, 7'd3, RSP_SILENT);
    configure(16'd1, 16'd1);
    run_transaction(FN_WR_COIL, 7'd0, RSP_SILENT);
  endtask

  task automatic test_functions();
    in_item_t it;
    configure(16'd3, 16'd2);
    for (int i = 0; i < 4; i++) begin
      next_request(it);
      it.cmd = CMD_LOAD;
      it.word_index = 7'(i);
      it.word_value = (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom());
      send_request(it);
    end
    run_transaction(FN_RD_HOLD, 7'd2, RSP_GOOD);
    run_transaction(FN_RD_INPUT, 7'd1, RSP_GOOD);
    run_transaction(FN_WR_COIL, 7'd0, RSP_GOOD);
    run_transaction(FN_WR_REG, 7'd0, RSP_GOOD);
    run_transaction(FN_EXC_STAT, 7'd0, RSP_GOOD);
    run_transaction(FN_DIAG, 7'd0, RSP_GOOD);
    run_transaction(FN_WR_MULTI, 7'd4, RSP_GOOD);
    run_transaction(FN_RD_HOLD, 7'd125, RSP_GOOD);
    for (int i = 0; i < 4; i++) begin
      next_request(it);
      make_read(it);
      send_request(it);
    end
  endtask

  task automatic test_status_cases();
    run_transaction(8'h00, 7'd1, RSP_GOOD);
    run_transaction(8'hFF, 7'd1, RSP_GOOD);
    run_transaction(FN_RD_HOLD, 7'd0, RSP_GOOD);
    run_transaction(FN_RD_INPUT, 7'd126, RSP_GOOD);
    run_transaction(FN_WR_MULTI, 7'd0, RSP_GOOD);
    run_transaction(FN_WR_MULTI, 7'd124, RSP_GOOD);
    run_transaction(FN_RD_HOLD, 7'd3, RSP_BAD_SLAVE);
    run_transaction(FN_WR_REG, 7'd0, RSP_BAD_FN);
    run_transaction(FN_EXC_STAT, 7'd0, RSP_BAD_CRC);
    run_transaction(FN_DIAG, 7'd0, RSP_SILENT);
    run_transaction(FN_RD_INPUT, 7'd2, RSP_LATE);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 3; ph++) begin
      configure(16'($urandom_range(1, 5)), 16'($urandom_range(0, 4)));
      no_idle = (ph == 1);
      random_requests(30);
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off while requests keep coming, so the queue fills.
  task automatic test_backpressure();
    hold_req = 1'b1;
    random_requests(40);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: random stalls and the long hold-off.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 15);
      end
    end
  end

  // Result checker and watchdog.
  initial begin
    out_item_t e;
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      quiet_cycles++;
      if ((in_valid && !in_stall) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      if (!rst && out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (out_item.kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_item.kind, e.kind));
          if (out_item.tx_data !== e.tx_data)
            report_mismatch($sformatf("tx_data %h, want %h", out_item.tx_data, e.tx_data));
          if (out_item.tx_last !== e.tx_last)
            report_mismatch($sformatf("tx_last %b, want %b", out_item.tx_last, e.tx_last));
          if (out_item.status !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_item.status, e.status));
          if (out_item.word_out !== e.word_out)
            report_mismatch($sformatf("word_out %h, want %h", out_item.word_out, e.word_out));
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    phase_sh    = M_IDLE;
    tx_pos      = 0;
    tx_len      = 0;
    rx_pos      = 0;
    rx_len      = 0;
    rx_crc      = 16'hFFFF;
    ticks_sh    = '0;
    attempts_sh = 0;
    hdr_err     = '0;
    req_slave   = '0;
    req_fn      = '0;
    req_cnt     = '0;
    timeout_sh  = 16'd1000;
    max_att_sh  = 4'd4;
    txn_mode    = RSP_GOOD;
    error_count = 0;
    items_sent  = 0;
    txn_count   = 0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    foreach (wr_loaded[i]) begin
      wr_loaded[i] = 1'b0;
      rd_loaded[i] = 1'b0;
    end
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_config_extremes();
    test_functions();
    test_status_cases();
    test_backpressure();
    test_random();
    drain_results();

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Covered %0d requests and %0d finished transactions.", items_sent, txn_count);
    $display("Status counts: ok %0d, unknown %0d, bad %0d, timeout %0d, slave %0d, count %0d",
             status_seen[ST_OK], status_seen[ST_UNKNOWN], status_seen[ST_BAD],
             status_seen[ST_TIMEOUT], status_seen[ST_SLAVE], status_seen[ST_COUNT]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_ram.sv
hw/rtl/mrtu_front.sv
hw/rtl/mrtu_back.sv
hw/rtl/modbus_rtu_master_transaction.sv
sim/tb_top.sv
